/* hdl/tid_pkg.sv */
// Shared types, codes and sizes of the TIM image decoder.
package tid_pkg;

	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int MAX_SIDE_DEF = 8192;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_PWR = 3'd1;
	localparam logic [2:0] OP_IDX = 3'd2;
	localparam logic [2:0] OP_555 = 3'd3;
	localparam logic [2:0] OP_RGB = 3'd4;
	localparam logic [2:0] OP_ERR = 3'd5;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_MAGIC = 3'd1;
	localparam logic [2:0] ERR_DEPTH = 3'd2;
	localparam logic [2:0] ERR_BLOCK_LEN = 3'd3;
	localparam logic [2:0] ERR_SIZE = 3'd4;
	localparam logic [2:0] ERR_NO_PALETTE = 3'd5;
	localparam logic [2:0] ERR_TRUNCATED = 3'd6;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_data;
	} in_beat_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [13:0] width;
		logic [13:0] height;
		logic [1:0] depth;
		logic [2:0] error_code;
		logic       last;
	} out_beat_t;

	// One command from the parser to the pixel engine.
	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  c;
		logic        two;
		logic        fin;
		logic        trunc;
		logic [2:0]  err;
		logic [13:0] w;
		logic [13:0] h;
		logic [1:0]  d;
	} cmd_t;

endpackage

/* hdl/tid_stream_if.sv */
// Valid/ready stream interface used for the byte and result channels.
interface tid_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* hdl/tim_image_to_rgba_decoder.sv */
// Top level of the TIM image decoder.
// Usage:
//   byte_in carries one file byte per beat, end_of_data set on the file's last byte.
//   result_out carries RGBA pixel results in raster order and error results
//   (kind set, last set, error_code given); each fault yields one error beat.
//   A byte is taken in every cycle while the command queue has room; a 4-bit
//   byte makes up to two pixels and other bytes at most one pixel, plus a
//   possible truncation error.
//   From byte beat to its first result beat the path is registered in the
//   queue, at engine issue with the palette RAM read, then in the output register.
//   The palette RAM's single read port sets one pixel per cycle as the rate while results are taken.
//   A stalled receiver holds the output register; the engine and then the
//   queue fill, and byte_in drops ready once the queue is full.
//   Reset clears the parser to wait for a header and empties the queue; the
//   palette contents are left as they are and survive from file to file.
module tim_image_to_rgba_decoder #(
	parameter int PALETTE_ENTRIES = tid_pkg::PALETTE_ENTRIES_DEF,
	parameter int MAX_SIDE = tid_pkg::MAX_SIDE_DEF
) (
	input logic         clk,
	input logic         arst_n,
	tid_stream_if.sink   byte_in,
	tid_stream_if.source result_out
);
	import tid_pkg::*;

	logic q_full;
	logic push;
	cmd_t cmd;
	logic pop;
	logic head_valid;
	cmd_t head;

	tid_front #(.PALETTE_ENTRIES(PALETTE_ENTRIES), .MAX_SIDE(MAX_SIDE)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(byte_in.valid),
		.in_data (byte_in.data),
		.in_ready(byte_in.ready),
		.q_full  (q_full),
		.push    (push),
		.cmd     (cmd)
	);

	tid_cmd_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (cmd),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	tid_back #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (result_out.valid),
		.out_data  (result_out.data),
		.out_ready (result_out.ready)
	);
endmodule

/* hdl/tid_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tid_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* hdl/tid_front.sv */
// Header parser: classifies each byte and turns it into at most one engine command.
module tid_front #(
	parameter int PALETTE_ENTRIES = tid_pkg::PALETTE_ENTRIES_DEF,
	parameter int MAX_SIDE = tid_pkg::MAX_SIDE_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  tid_pkg::in_beat_t in_data,
	output logic            in_ready,
	input  logic            q_full,
	output logic            push,
	output tid_pkg::cmd_t   cmd
);
	import tid_pkg::*;

	localparam int AW = $clog2(PALETTE_ENTRIES);

	localparam logic [2:0] PH_MAGIC = 3'd0;
	localparam logic [2:0] PH_FLAGS = 3'd1;
	localparam logic [2:0] PH_PAL_HDR = 3'd2;
	localparam logic [2:0] PH_PAL_DATA = 3'd3;
	localparam logic [2:0] PH_PIX_HDR = 3'd4;
	localparam logic [2:0] PH_PIXELS = 3'd5;
	localparam logic [2:0] PH_DONE = 3'd6;
	localparam logic [2:0] PH_DRAIN = 3'd7;

	logic [2:0]  phase_q, phase_n;
	logic [31:0] fbc_q, fbc_n;
	logic [31:0] hw_q, hw_n;
	logic [31:0] pbl_q, pbl_n;
	logic [31:0] plim_q, plim_n;
	logic [15:0] cw_q, cw_n;
	logic [15:0] ih_q, ih_n;
	logic [16:0] col_q, col_n;
	logic [13:0] row_q, row_n;
	logic [15:0] part_q, part_n;
	logic [1:0]  pos3_q, pos3_n;
	logic [13:0] x3_q, x3_n;
	logic [1:0]  dep_q, dep_n;
	logic        hasp_q, hasp_n;
	logic [13:0] iw_q, iw_n;

	logic        accept;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;

	function automatic logic [7:0] remap(input logic [3:0] dummy, input logic [7:0] idx,
		input logic [31:0] lim);
		logic [AW-1:0] r;
		r = '0;
		if ({24'd0, idx} < lim && {1'b0, idx} < 9'(PALETTE_ENTRIES)) begin
			r = idx[AW-1:0];
		end
		remap = 8'(r);
		if (dummy != 4'd0) begin
			remap = 8'(r);
		end
	endfunction

	always_comb begin
		logic [7:0]  b;
		logic [31:0] pos;
		logic [31:0] shb;
		logic [31:0] hwb;
		logic [31:0] k;
		logic [17:0] wc;
		logic [16:0] x2;
		logic [34:0] prod;
		logic        lastrow;
		logic [17:0] x0;
		logic        fin0;
		logic        fin1;
		logic [17:0] coln;

		b = in_data.byte_value;
		pos = fbc_q;
		shb = {24'd0, b} << {pos[1:0], 3'b000};
		hwb = hw_q | shb;
		k = pos - 32'd12;
		wc = '0;
		x2 = '0;
		prod = '0;
		lastrow = ({3'd0, row_q} + 17'd1) == {1'b0, ih_q};
		x0 = {col_q, 1'b0};
		fin0 = 1'b0;
		fin1 = 1'b0;
		coln = '0;

		phase_n = phase_q; fbc_n = fbc_q; hw_n = hw_q; pbl_n = pbl_q; plim_n = plim_q;
		cw_n = cw_q; ih_n = ih_q; col_n = col_q; row_n = row_q; part_n = part_q;
		pos3_n = pos3_q; x3_n = x3_q; dep_n = dep_q; hasp_n = hasp_q; iw_n = iw_q;

		cmd = '0;
		cmd.w = iw_q;
		cmd.h = ih_q[13:0];
		cmd.d = dep_q;

		case (phase_q)
			PH_MAGIC: begin
				if (b != ((pos == 32'd0) ? 8'h10 : 8'h00)) begin
					cmd.op = OP_ERR; cmd.err = ERR_MAGIC; phase_n = PH_DRAIN;
				end else begin
					fbc_n = pos + 32'd1;
					if (pos == 32'd3) begin
						phase_n = PH_FLAGS; fbc_n = '0; hw_n = '0;
					end
				end
			end
			PH_FLAGS: begin
				hw_n = hwb;
				fbc_n = pos + 32'd1;
				if (pos == 32'd3) begin
					if (hwb[2:0] > 3'd3) begin
						cmd.op = OP_ERR; cmd.err = ERR_DEPTH; phase_n = PH_DRAIN;
					end else begin
						dep_n = hwb[1:0];
						hasp_n = hwb[3];
						fbc_n = '0;
						hw_n = '0;
						phase_n = hwb[3] ? PH_PAL_HDR : PH_PIX_HDR;
					end
				end
			end
			PH_PAL_HDR: begin
				if (pos < 32'd4) begin
					pbl_n = pbl_q | shb;
				end else if (pos >= 32'd8) begin
					hw_n = hwb;
				end
				fbc_n = pos + 32'd1;
				if (pos == 32'd11) begin
					plim_n = hwb[15:0] * hwb[31:16];
					hw_n = '0;
					if (pbl_q < 32'd12) begin
						cmd.op = OP_ERR; cmd.err = ERR_BLOCK_LEN; phase_n = PH_DRAIN;
					end else if (pbl_q == 32'd12) begin
						phase_n = PH_PIX_HDR; fbc_n = '0;
					end else begin
						phase_n = PH_PAL_DATA;
					end
				end
			end
			PH_PAL_DATA: begin
				if ({1'b0, k[31:1]} < 32'(PALETTE_ENTRIES)) begin
					if (!k[0]) begin
						part_n = {8'd0, b};
					end else begin
						cmd.op = OP_PWR;
						cmd.a = 8'(k[AW:1]);
						cmd.b = part_q[7:0];
						cmd.c = b;
					end
				end
				fbc_n = pos + 32'd1;
				if ({1'b0, pos} + 33'd1 >= {1'b0, pbl_q}) begin
					phase_n = PH_PIX_HDR; fbc_n = '0;
				end
			end
			PH_PIX_HDR: begin
				if (pos >= 32'd8) begin
					hw_n = hwb;
				end
				fbc_n = pos + 32'd1;
				if (pos == 32'd11) begin
					cw_n = hwb[15:0];
					ih_n = hwb[31:16];
					hw_n = '0;
					fbc_n = '0;
					case (dep_q)
						2'd0: wc = {hwb[15:0], 2'b00};
						2'd1: wc = {1'b0, hwb[15:0], 1'b0};
						2'd2: wc = {2'b00, hwb[15:0]};
						default: begin
							// Divide by three through a reciprocal, exact below 2^17.
							x2 = {hwb[15:0], 1'b0};
							prod = x2 * 18'd87382;
							wc = {1'b0, prod[34:18]};
						end
					endcase
					iw_n = wc[13:0];
					if (wc == 18'd0 || hwb[31:16] == 16'd0 || wc > 18'(MAX_SIDE)
						|| hwb[31:16] > 16'(MAX_SIDE)) begin
						cmd.op = OP_ERR; cmd.err = ERR_SIZE; phase_n = PH_DRAIN;
					end else if (!dep_q[1] && !hasp_q) begin
						cmd.op = OP_ERR; cmd.err = ERR_NO_PALETTE; phase_n = PH_DRAIN;
					end else begin
						phase_n = PH_PIXELS;
						col_n = '0; row_n = '0; pos3_n = '0; x3_n = '0;
					end
				end
			end
			PH_PIXELS: begin
				case (dep_q)
					2'd0: begin
						cmd.op = OP_IDX;
						cmd.a = remap(4'd0, {4'd0, b[3:0]}, plim_q);
						cmd.b = remap(4'd0, {4'd0, b[7:4]}, plim_q);
						fin0 = lastrow && (x0 + 18'd1 == {4'd0, iw_q});
						fin1 = lastrow && (x0 + 18'd2 == {4'd0, iw_q});
						if (fin0) begin
							cmd.fin = 1'b1; phase_n = PH_DONE;
						end else begin
							cmd.two = 1'b1; cmd.fin = fin1;
							if (fin1) phase_n = PH_DONE;
						end
					end
					2'd1: begin
						cmd.op = OP_IDX;
						cmd.a = remap(4'd0, b, plim_q);
						cmd.fin = lastrow && ({1'b0, col_q} + 18'd1 == {4'd0, iw_q});
						if (cmd.fin) phase_n = PH_DONE;
					end
					2'd2: begin
						if (!col_q[0]) begin
							part_n = {8'd0, b};
						end else begin
							cmd.op = OP_555;
							cmd.a = part_q[7:0];
							cmd.b = b;
							cmd.fin = lastrow && ({2'd0, col_q[16:1]} + 18'd1 == {4'd0, iw_q});
							if (cmd.fin) phase_n = PH_DONE;
						end
					end
					default: begin
						if ({1'b0, col_q} < 18'd3 * {4'd0, iw_q}) begin
							case (pos3_q)
								2'd0: part_n = {8'd0, b};
								2'd1: part_n = {b, part_q[7:0]};
								default: begin
									cmd.op = OP_RGB;
									cmd.a = part_q[7:0];
									cmd.b = part_q[15:8];
									cmd.c = b;
									cmd.fin = lastrow && (x3_q + 14'd1 == iw_q);
									if (cmd.fin) phase_n = PH_DONE;
								end
							endcase
						end
					end
				endcase
				if (phase_n == PH_PIXELS) begin
					coln = {1'b0, col_q} + 18'd1;
					if (pos3_q == 2'd2) begin
						pos3_n = '0; x3_n = x3_q + 14'd1;
					end else begin
						pos3_n = pos3_q + 2'd1;
					end
					if (coln >= {1'b0, cw_q, 1'b0}) begin
						col_n = '0; row_n = row_q + 14'd1; pos3_n = '0; x3_n = '0;
					end else begin
						col_n = coln[16:0];
					end
				end
			end
			default: begin
			end
		endcase

		if (in_data.end_of_data) begin
			if (phase_n != PH_DONE && phase_n != PH_DRAIN) begin
				cmd.trunc = 1'b1;
			end
			phase_n = PH_MAGIC; fbc_n = '0; hw_n = '0; pbl_n = '0; plim_n = '0;
			cw_n = '0; ih_n = '0; col_n = '0; row_n = '0; part_n = '0;
			pos3_n = '0; x3_n = '0; dep_n = '0; hasp_n = 1'b0; iw_n = '0;
		end
	end

	assign push = accept && (cmd.op != OP_NONE || cmd.trunc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC; fbc_q <= '0; hw_q <= '0; pbl_q <= '0; plim_q <= '0;
			cw_q <= '0; ih_q <= '0; col_q <= '0; row_q <= '0; part_q <= '0;
			pos3_q <= '0; x3_q <= '0; dep_q <= '0; hasp_q <= 1'b0; iw_q <= '0;
		end else if (accept) begin
			phase_q <= phase_n; fbc_q <= fbc_n; hw_q <= hw_n; pbl_q <= pbl_n;
			plim_q <= plim_n; cw_q <= cw_n; ih_q <= ih_n; col_q <= col_n;
			row_q <= row_n; part_q <= part_n; pos3_q <= pos3_n; x3_q <= x3_n;
			dep_q <= dep_n; hasp_q <= hasp_n; iw_q <= iw_n;
		end
	end
endmodule

/* hdl/tid_cmd_fifo.sv */
// Short command queue between the parser and the pixel engine.
module tid_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tid_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output tid_pkg::cmd_t head
);
	import tid_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   cnt_q;

	assign full = cnt_q == (PW+1)'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + PW'(1);
			if (pop) rp_q <= rp_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end
endmodule

/* hdl/tid_back.sv */
// Pixel engine: palette writes and reads, color widening and result output.
module tid_back #(
	parameter int PALETTE_ENTRIES = tid_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  tid_pkg::cmd_t    head,
	output logic             pop,
	output logic             out_valid,
	output tid_pkg::out_beat_t out_data,
	input  logic             out_ready
);
	import tid_pkg::*;

	localparam int AW = $clog2(PALETTE_ENTRIES);

	typedef struct packed {
		logic        err;
		logic [2:0]  code;
		logic        use_pal;
		logic        rgb;
		logic [23:0] val;
		logic        last;
		logic [13:0] w;
		logic [13:0] h;
		logic [1:0]  d;
	} s1_t;

	logic [1:0]    cnt_q;
	logic          s1_v_s1;
	s1_t           s1_s1;
	logic          out_v_q;
	out_beat_t     out_q;

	logic [1:0]    main_n;
	logic [1:0]    total;
	logic          out_free;
	logic          s1_free;
	logic          issue;
	logic          load;
	s1_t           s1_n;
	logic          we;
	logic          re;
	logic [AW-1:0] raddr;
	logic [15:0]   rdata;
	out_beat_t     form;

	assign out_free = !out_v_q || out_ready;
	assign s1_free = !s1_v_s1 || out_free;
	assign issue = head_valid && s1_free;

	always_comb begin
		case (head.op)
			OP_NONE: main_n = 2'd0;
			OP_IDX: main_n = head.two ? 2'd2 : 2'd1;
			default: main_n = 2'd1;
		endcase
	end

	assign total = main_n + {1'b0, head.trunc};
	assign pop = issue && (cnt_q == total - 2'd1);

	always_comb begin
		load = 1'b0;
		we = 1'b0;
		re = 1'b0;
		raddr = head.a[AW-1:0];
		s1_n = '0;
		s1_n.w = head.w;
		s1_n.h = head.h;
		s1_n.d = head.d;
		if (cnt_q < main_n) begin
			case (head.op)
				OP_PWR: we = issue;
				OP_IDX: begin
					load = 1'b1;
					re = issue;
					if (cnt_q != 2'd0) raddr = head.b[AW-1:0];
					s1_n.use_pal = 1'b1;
					s1_n.last = head.fin && (cnt_q == main_n - 2'd1);
				end
				OP_555: begin
					load = 1'b1;
					s1_n.val = {8'd0, head.b, head.a};
					s1_n.last = head.fin;
				end
				OP_RGB: begin
					load = 1'b1;
					s1_n.rgb = 1'b1;
					s1_n.val = {head.c, head.b, head.a};
					s1_n.last = head.fin;
				end
				default: begin
					load = 1'b1;
					s1_n.err = 1'b1;
					s1_n.code = head.err;
				end
			endcase
		end else begin
			// A file that ended early closes with its truncation error.
			load = 1'b1;
			s1_n.err = 1'b1;
			s1_n.code = ERR_TRUNCATED;
		end
	end

	tid_ram #(.WIDTH(16), .DEPTH(PALETTE_ENTRIES)) u_palette (
		.clk  (clk),
		.we   (we),
		.waddr(head.a[AW-1:0]),
		.wdata({head.c, head.b}),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		logic [15:0] c16;
		c16 = s1_s1.use_pal ? rdata : s1_s1.val[15:0];
		form = '0;
		if (s1_s1.err) begin
			form.kind = 1'b1;
			form.error_code = s1_s1.code;
			form.last = 1'b1;
		end else begin
			form.width = s1_s1.w;
			form.height = s1_s1.h;
			form.depth = s1_s1.d;
			form.last = s1_s1.last;
			if (s1_s1.rgb) begin
				form.red = s1_s1.val[7:0];
				form.green = s1_s1.val[15:8];
				form.blue = s1_s1.val[23:16];
				form.alpha = 8'hFF;
			end else begin
				form.red = {c16[4:0], c16[4:2]};
				form.green = {c16[9:5], c16[9:7]};
				form.blue = {c16[14:10], c16[14:12]};
				form.alpha = (c16 != 16'd0) ? 8'hFF : 8'h00;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			s1_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pop) cnt_q <= '0;
			else if (issue) cnt_q <= cnt_q + 2'd1;
			if (issue && load) s1_v_s1 <= 1'b1;
			else if (s1_v_s1 && out_free) s1_v_s1 <= 1'b0;
			if (s1_v_s1 && out_free) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue && load) s1_s1 <= s1_n;
		if (s1_v_s1 && out_free) out_q <= form;
	end

	assign out_valid = out_v_q;
	assign out_data = out_q;
endmodule
